// File: sv/pcg_pkg.sv
// Package for the PCG32 generator: payload types, codes, constants and the output permutation.
package pcg_pkg;

  // LCG multiplier, split into 32-bit halves for the shared multiplier
  localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
  localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
  localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];
  localparam logic [63:0] INC_RESET   = 64'd1442695040888963407;

  // Request modes
  localparam logic [1:0] MODE_SEED   = 2'd0;
  localparam logic [1:0] MODE_DRAW32 = 2'd1;
  localparam logic [1:0] MODE_DRAW64 = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] seed_value;
  } pcg_in_t;

  typedef struct packed {
    logic [63:0] random_value;
    logic        is_wide;
  } pcg_out_t;

  // Multiply-accumulate controls
  typedef struct packed {
    logic load;    // acc = product + addend
    logic add_hi;  // acc += product << 32
  } mac_ctl_t;

  // XSH-RR permutation of the pre-step state
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] xs;
    logic [31:0] x;
    logic [4:0]  r;
    logic [63:0] dbl;
    logic [63:0] rot;
    xs  = (s >> 18) ^ s;
    x   = xs[58:27];
    r   = s[63:59];
    dbl = {x, x};
    rot = dbl >> r;
    return rot[31:0];
  endfunction

endpackage

// File: sv/pcg_mac.sv
// Shared 32x32 multiplier with a registered product and a 64-bit accumulator.
module pcg_mac
  import pcg_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  input  mac_ctl_t    ctl,
  input  logic [63:0] addend,
  output logic [63:0] acc
);

  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;

  // Accumulate step: full load, or add into the upper word only
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = prod_r + addend;
    end else if (ctl.add_hi) begin
      acc_nxt = {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: sv/pcg32_random_generator_unit.sv
// Top level of the PCG32 XSH-RR generator: sequencer, state, config and output register.
//
// Input channel (in_valid / in_stall / in_data): one request per transaction.
//   Mode 0 reseeds (state = seed + increment, then one discarded step), no result.
//   Mode 1 returns one 32-bit draw, mode 2 returns two draws packed into 64 bits
//   (first draw high). Mode 3 is dropped without effect.
// Output channel (out_valid / out_stall / out_data): one transaction per draw request.
// Config port: cfg_wr_en / cfg_wr_data write the increment; write only while idle.
// Sequence: each LCG step runs through ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3 and ST_UPD on the
//   one shared 32x32 multiplier (three partial products, accumulate, state update). A mode 1
//   result goes to the output register after one step, a mode 2 result after two; a reseed
//   occupies the block for one step. in_stall is high from acceptance until the
//   result has been loaded into the output register.
// Stall: a waiting result sits in the output register; the next request can be
//   accepted meanwhile, and its own result waits until that register is free.
// Reset: state clears to zero, increment returns to its default, no output valid.
module pcg32_random_generator_unit
  import pcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pcg_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pcg_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL0 = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_MUL3 = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } seq_state_t;

  seq_state_t  state_r, state_nxt;
  logic [63:0] lcg_r, lcg_nxt;
  logic [63:0] inc_r;
  logic [63:0] word_r, word_nxt;
  logic        more_r, more_nxt;   // second draw still to run
  logic        emit_r, emit_nxt;   // request produces a result
  logic        wide_r, wide_nxt;
  logic        out_valid_r, out_valid_nxt;
  pcg_out_t    out_data_r, out_data_nxt;

  logic [31:0] op_a, op_b;
  mac_ctl_t    mac_ctl;
  logic [63:0] acc;
  logic        in_acc;
  logic        out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  pcg_mac u_mac (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .ctl    (mac_ctl),
    .addend (inc_r),
    .acc    (acc)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    lcg_nxt       = lcg_r;
    word_nxt      = word_r;
    more_nxt      = more_r;
    emit_nxt      = emit_r;
    wide_nxt      = wide_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    op_a          = lcg_r[31:0];
    op_b          = LCG_MULT_LO;
    mac_ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          word_nxt = '0;
          more_nxt = (in_data.mode == MODE_DRAW64);
          wide_nxt = (in_data.mode == MODE_DRAW64);
          emit_nxt = (in_data.mode == MODE_DRAW32) || (in_data.mode == MODE_DRAW64);
          if (in_data.mode == MODE_SEED) begin
            lcg_nxt   = in_data.seed_value + inc_r;
            state_nxt = ST_MUL0;
          end else if ((in_data.mode == MODE_DRAW32) || (in_data.mode == MODE_DRAW64)) begin
            state_nxt = ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        // low x low product issued; draw taken from the pre-step state
        word_nxt  = {word_r[31:0], xsh_rr(lcg_r)};
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        op_a         = lcg_r[63:32];
        mac_ctl.load = 1'b1;
        state_nxt    = ST_MUL2;
      end
      ST_MUL2: begin
        op_b           = LCG_MULT_HI;
        mac_ctl.add_hi = 1'b1;
        state_nxt      = ST_MUL3;
      end
      ST_MUL3: begin
        mac_ctl.add_hi = 1'b1;
        state_nxt      = ST_UPD;
      end
      ST_UPD: begin
        lcg_nxt = acc;
        if (more_r) begin
          more_nxt  = 1'b0;
          state_nxt = ST_MUL0;
        end else if (emit_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.random_value = word_r;
          out_data_nxt.is_wide      = wide_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lcg_r       <= '0;
      inc_r       <= INC_RESET;
      out_valid_r <= 1'b0;
      more_r      <= 1'b0;
      emit_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcg_r       <= lcg_nxt;
      out_valid_r <= out_valid_nxt;
      more_r      <= more_nxt;
      emit_r      <= emit_nxt;
      if (cfg_wr_en) begin
        inc_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    wide_r     <= wide_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the PCG32 XSH-RR generator unit.
module tb;
  import pcg_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         RESET_CYCLES = 5;
  localparam int         DRAIN_CYCLES = 32;
  localparam int         LIMIT_CYCLES = 600000;
  localparam int         SEG_ITEMS    = 275;
  localparam int         LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pcg_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pcg_out_t    out_data;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;

  // Stimulus and scoreboard storage
  pcg_in_t     req_queue[$];
  pcg_out_t    draw_queue[$];
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_left = 0;
  int          err_count = 0;
  int          cycle_count = 0;

  // Generator model state
  logic [63:0] model_state = '0;
  logic [63:0] model_inc = INC_RESET;

  pcg32_random_generator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock and one reset pulse
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // One LCG step on the model; returns the permuted draw of the old state
  function automatic logic [31:0] next_draw();
    logic [63:0] s;
    logic [63:0] xs;
    logic [31:0] x;
    logic [4:0]  r;
    s           = model_state;
    model_state = s * LCG_MULT + model_inc;
    xs          = ((s >> 18) ^ s) >> 27;
    x           = xs[31:0];
    r           = s[63:59];
    return (x >> r) | (x << 5'(~r + 5'd1));
  endfunction

  // Driver: next request goes out once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (req_queue.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= req_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: long hold first, random idling otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Predictor: config writes and accepted requests update the model
  always @(posedge clk) begin
    pcg_out_t    exp_draw;
    logic [31:0] hi_word;
    logic [31:0] lo_word;
    if (!rst_n) begin
      model_state = '0;
      model_inc   = INC_RESET;
    end else begin
      if (cfg_wr_en) model_inc = cfg_wr_data;
      if (in_valid && !in_stall) begin
        case (in_data.mode)
          MODE_SEED: begin
            model_state = in_data.seed_value + model_inc;
            void'(next_draw());
          end
          MODE_DRAW32: begin
            exp_draw.random_value = {32'd0, next_draw()};
            exp_draw.is_wide      = 1'b0;
            draw_queue.push_back(exp_draw);
          end
          MODE_DRAW64: begin
            hi_word               = next_draw();
            lo_word               = next_draw();
            exp_draw.random_value = {hi_word, lo_word};
            exp_draw.is_wide      = 1'b1;
            draw_queue.push_back(exp_draw);
          end
          default: ;
        endcase
      end
    end
  end

  // Monitor: compare each delivered draw with the oldest prediction
  always @(posedge clk) begin
    pcg_out_t exp_draw;
    if (rst_n && out_valid && !out_stall) begin
      if (draw_queue.size() == 0) begin
        err_count <= err_count + 1;
        if (err_count < 10)
          $display("ERROR: unexpected draw value=%h wide=%b",
                   out_data.random_value, out_data.is_wide);
      end else begin
        exp_draw = draw_queue.pop_front();
        if (out_data.random_value !== exp_draw.random_value ||
            out_data.is_wide !== exp_draw.is_wide) begin
          err_count <= err_count + 1;
          if (err_count < 10)
            $display("ERROR: draw mismatch exp value=%h wide=%b got value=%h wide=%b",
                     exp_draw.random_value, exp_draw.is_wide,
                     out_data.random_value, out_data.is_wide);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] mode, input logic [63:0] seed);
    pcg_in_t req;
    req.mode       = mode;
    req.seed_value = seed;
    req_queue.push_back(req);
  endtask

  // Wait until every request is taken and every draw has arrived, then drain
  task automatic wait_idle();
    do @(negedge clk);
    while (req_queue.size() > 0 || in_valid || draw_queue.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_increment(input logic [63:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly random draw requests with occasional reseeds, stray unused modes and extreme seeds
  task automatic gen_random(input int count);
    int          done;
    int          pick;
    logic [63:0] seed;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      seed = {$urandom, $urandom};
      case ($urandom_range(15))
        0: seed = '0;
        1: seed = '1;
        default: ;
      endcase
      if (pick < 10) begin
        push_req(MODE_SEED, seed);
        done++;
      end else if (pick < 50) begin
        push_req(MODE_DRAW32, seed);
        done++;
      end else if (pick < 95) begin
        push_req(MODE_DRAW64, seed);
        done++;
      end else begin
        push_req(MODE_UNUSED, seed);
      end
    end
  endtask

  // Test sequence
  initial begin
    logic [63:0] inc_list[6];
    inc_list[0] = 64'd0;
    inc_list[1] = '1;
    inc_list[2] = {$urandom, $urandom} | 64'd1;
    inc_list[3] = {$urandom, $urandom} & ~64'd1;
    inc_list[4] = INC_RESET;
    inc_list[5] = 64'h8000_0000_0000_0001;

    @(posedge rst_n);
    @(negedge clk);

    // Directed: draws from the unseeded state, unused mode, extreme seeds
    snd_idle_pct = 38;
    rcv_idle_pct = 55;
    push_req(MODE_DRAW32, '1);
    push_req(MODE_DRAW64, '0);
    push_req(MODE_UNUSED, '1);
    push_req(MODE_DRAW32, '0);
    push_req(MODE_SEED, '0);
    push_req(MODE_DRAW32, '0);
    push_req(MODE_DRAW64, '1);
    push_req(MODE_SEED, '1);
    push_req(MODE_DRAW32, '0);
    push_req(MODE_DRAW64, '0);
    push_req(MODE_UNUSED, '0);
    push_req(MODE_DRAW32, '0);
    push_req(MODE_SEED, 64'h8000_0000_0000_0000);
    push_req(MODE_DRAW64, '0);
    push_req(MODE_DRAW64, '0);
    push_req(MODE_SEED, 64'h5555_5555_5555_5555);
    push_req(MODE_DRAW32, '0);
    push_req(MODE_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
    push_req(MODE_DRAW64, '0);
    push_req(MODE_SEED, 64'h0000_0000_0000_0001);
    push_req(MODE_DRAW32, '0);
    wait_idle();

    // Random segments, each with its own increment and one of three idling patterns
    for (int seg = 0; seg < 6; seg++) begin
      write_increment(inc_list[seg]);
      if (seg < 2) begin
        snd_idle_pct = 38;
        rcv_idle_pct = 55;
      end else if (seg < 4) begin
        snd_idle_pct = 55;
        rcv_idle_pct = 38;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // receiver holds off while the sender keeps offering
      if (seg == 1 || seg == 4) hold_left = LONG_HOLD;
      gen_random(SEG_ITEMS / 2);
      // sender pauses until the block has delivered everything
      if (seg == 5) wait_idle();
      gen_random(SEG_ITEMS - SEG_ITEMS / 2);
      wait_idle();
    end

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: pcg32_random_generator_unit.f
sv/pcg_pkg.sv
sv/pcg_mac.sv
sv/pcg32_random_generator_unit.sv
dv/tb.sv
